[src/ictf_pkg.sv]
`timescale 1ns / 1ps

package ictf_pkg;

	// Input item: one IMU sample
	typedef struct packed {
		logic signed [15:0] gyro_x_raw;
		logic signed [15:0] gyro_y_raw;
		logic signed [15:0] gyro_z_raw;
		logic signed [15:0] accel_x_raw;
		logic signed [15:0] accel_y_raw;
		logic signed [15:0] accel_z_raw;
		logic        [15:0] elapsed_ms;
		logic               gyro_ok;
		logic               accel_ok;
	} imu_in_t;

	// Result item: angles in signed fixed point degrees
	typedef struct packed {
		logic signed [31:0] angle_x;
		logic signed [31:0] angle_y;
		logic signed [31:0] angle_z;
		logic signed [31:0] tilt_x;
		logic signed [31:0] tilt_y;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic        [1:0]  status;
	} imu_out_t;

	localparam int TAB_LEN        = 24;
	localparam int TAB_SCALE_BITS = 24;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_GYRO_FAIL = 2'd1;
	localparam logic [1:0] ST_ACC_FAIL  = 2'd2;

	// atan(2^-i) in degrees, scaled by 2^24
	function automatic logic [31:0] atan_deg(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:    v = 32'd754974720;
			5'd1:    v = 32'd445687602;
			5'd2:    v = 32'd235489088;
			5'd3:    v = 32'd119537938;
			5'd4:    v = 32'd60000934;
			5'd5:    v = 32'd30029717;
			5'd6:    v = 32'd15018523;
			5'd7:    v = 32'd7509720;
			5'd8:    v = 32'd3754917;
			5'd9:    v = 32'd1877466;
			5'd10:   v = 32'd938734;
			5'd11:   v = 32'd469367;
			5'd12:   v = 32'd234684;
			5'd13:   v = 32'd117342;
			5'd14:   v = 32'd58671;
			5'd15:   v = 32'd29335;
			5'd16:   v = 32'd14668;
			5'd17:   v = 32'd7334;
			5'd18:   v = 32'd3667;
			5'd19:   v = 32'd1833;
			5'd20:   v = 32'd917;
			5'd21:   v = 32'd458;
			5'd22:   v = 32'd229;
			5'd23:   v = 32'd115;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

[src/imu_complementary_tilt_filter_unit.sv]
`timescale 1ns / 1ps

// Complementary tilt filter for one IMU sample per item. Gyro rates are scaled by the
// sensitivity register, bias corrected and integrated into three angles; with a good
// accelerometer read, roll and pitch are taken by a square root and CORDIC, blended in
// at 0.96/0.04 and all angles published. One item at a time; a failed gyro read skips
// all work, a failed accelerometer read skips the tilt and blend, and CORDIC steps are
// capped at 24. Work runs on the one shared bit-serial divider, eight divisions per full
// item, plus a serial multiply per axis, the square root and one CORDIC step per cycle.
// The result sits in an output register; the next item is taken once the result has been
// loaded there, and a result still waiting there holds the following item in its last
// step until it is taken.
module imu_complementary_tilt_filter_unit #(
	parameter int ANGLE_FRAC_BITS = 16,
	parameter int CORDIC_STEPS    = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ictf_pkg::imu_in_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output ictf_pkg::imu_out_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [15:0]       cfg_data
);

	localparam int NSTEP = (CORDIC_STEPS > ictf_pkg::TAB_LEN) ? ictf_pkg::TAB_LEN
		: CORDIC_STEPS;
	localparam int ZSH   = ictf_pkg::TAB_SCALE_BITS - ANGLE_FRAC_BITS;
	localparam longint ONE_Q  = longint'(1) << ANGLE_FRAC_BITS;
	localparam longint BIAS_X = (293 * ONE_Q + 50) / 100;
	localparam longint BIAS_Y = -((127 * ONE_Q + 50) / 100);
	localparam longint BIAS_Z = (145 * ONE_Q + 50) / 100;
	localparam longint TOFF_X = (32 * ONE_Q + 50) / 100;
	localparam longint TOFF_Y = -((40 * ONE_Q + 50) / 100);
	localparam logic [33:0] ZHALF = 34'((64'd1 << ZSH) >> 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RSET = 4'd1;
	localparam logic [3:0] S_RDIV = 4'd2;
	localparam logic [3:0] S_MUL  = 4'd3;
	localparam logic [3:0] S_DDIV = 4'd4;
	localparam logic [3:0] S_GADD = 4'd5;
	localparam logic [3:0] S_SQB  = 4'd6;
	localparam logic [3:0] S_SQC  = 4'd7;
	localparam logic [3:0] S_SQRT = 4'd8;
	localparam logic [3:0] S_CORD = 4'd9;
	localparam logic [3:0] S_TSET = 4'd10;
	localparam logic [3:0] S_BSET = 4'd11;
	localparam logic [3:0] S_BDIV = 4'd12;
	localparam logic [3:0] S_BUPD = 4'd13;
	localparam logic [3:0] S_DONE = 4'd14;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	logic [3:0]  state_q;
	logic [1:0]  idx_q;
	logic [5:0]  cnt_q;
	logic [1:0]  status_q;
	logic [15:0] sens_q;
	ictf_pkg::imu_in_t item_q;
	logic signed [31:0] gyro_q [3];
	logic signed [31:0] tilt_q [2];
	logic signed [31:0] pub_q  [3];

	// serial divider
	logic [63:0] dn_q, quo_q;
	logic [16:0] rem_q;
	logic [15:0] den_q;
	logic        neg_q;
	// serial multiplier
	logic signed [63:0] acc_q, val_q;
	logic [15:0] ms_q;
	// square root and CORDIC
	logic [31:0] sq_q;
	logic [63:0] m_q;
	logic [33:0] srem_q;
	logic [31:0] root_q;
	logic signed [33:0] cx_q, cy_q;
	logic signed [32:0] cz_q;
	logic        zero_q;

	logic signed [15:0] raw_c;
	logic signed [63:0] div_num_c, div_res_c, blend_num_c, tilt_sum_c;
	logic [15:0] div_den_c, sens_eff_c;
	logic [16:0] trial_rem_c;
	logic [33:0] srem_sh_c, strial_c;
	logic signed [16:0] num_c;
	logic signed [15:0] b_c;
	logic signed [33:0] xs_c, ys_c;
	logic [32:0] zmag_c;
	logic signed [32:0] zr_c;
	logic signed [63:0] bias_c, toff_c;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	// operand selection
	always_comb begin
		case (idx_q)
			2'd1:    raw_c = item_q.gyro_y_raw;
			2'd2:    raw_c = item_q.gyro_z_raw;
			default: raw_c = item_q.gyro_x_raw;
		endcase
		case (idx_q)
			2'd1:    bias_c = 64'(BIAS_Y);
			2'd2:    bias_c = 64'(BIAS_Z);
			default: bias_c = 64'(BIAS_X);
		endcase
		toff_c = idx_q[0] ? 64'(TOFF_Y) : 64'(TOFF_X);
		if (idx_q[0]) begin
			num_c = -17'(item_q.accel_x_raw);
			b_c   = item_q.accel_y_raw;
		end else begin
			num_c = 17'(item_q.accel_y_raw);
			b_c   = item_q.accel_x_raw;
		end
		sens_eff_c  = (sens_q == 16'd0) ? 16'd1 : sens_q;
		blend_num_c = (64'(gyro_q[idx_q[0]]) <<< 6) + (64'(gyro_q[idx_q[0]]) <<< 5)
			+ (64'(tilt_q[idx_q[0]]) <<< 2);
		case (state_q)
			S_MUL: begin
				div_num_c = acc_q;
				div_den_c = 16'd1000;
			end
			S_BSET: begin
				div_num_c = blend_num_c;
				div_den_c = 16'd100;
			end
			default: begin
				div_num_c = ((64'(raw_c) <<< 3) + (64'(raw_c) <<< 1)) <<< ANGLE_FRAC_BITS;
				div_den_c = sens_eff_c;
			end
		endcase
		div_res_c   = neg_q ? -$signed(quo_q) : $signed(quo_q);
		trial_rem_c = {rem_q[15:0], dn_q[63]};
		srem_sh_c   = {srem_q[31:0], m_q[63:62]};
		strial_c    = {root_q, 2'b01};
		xs_c        = cx_q >>> cnt_q[4:0];
		ys_c        = cy_q >>> cnt_q[4:0];
		zmag_c      = cz_q[32] ? 33'(-cz_q) : 33'(cz_q);
		zr_c        = cz_q[32] ? -$signed(33'((34'(zmag_c) + ZHALF) >> ZSH))
			: $signed(33'((34'(zmag_c) + ZHALF) >> ZSH));
		tilt_sum_c  = (zero_q ? 64'sd0 : 64'(zr_c)) + toff_c;
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q <= 16'd1310;
		end else if (cfg_valid && cfg_ready) begin
			sens_q <= cfg_data;
		end
	end

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			idx_q     <= 2'd0;
			cnt_q     <= 6'd0;
			status_q  <= ictf_pkg::ST_OK;
			out_valid <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				gyro_q[i] <= '0;
				pub_q[i]  <= '0;
			end
			tilt_q[0] <= '0;
			tilt_q[1] <= '0;
		end else begin
			if (out_valid && out_ready && (state_q != S_DONE))
				out_valid <= 1'b0;
			unique case (state_q) inside
				S_IDLE: begin
					if (in_valid) begin
						item_q <= in_data;
						idx_q  <= 2'd0;
						if (in_data.gyro_ok) begin
							status_q <= ictf_pkg::ST_OK;
							state_q  <= S_RSET;
						end else begin
							status_q <= ictf_pkg::ST_GYRO_FAIL;
							state_q  <= S_DONE;
						end
					end
				end
				S_RSET, S_BSET: begin
					dn_q    <= (div_num_c[63] ? 64'(-div_num_c) : 64'(div_num_c))
						+ 64'(div_den_c >> 1);
					neg_q   <= div_num_c[63];
					den_q   <= div_den_c;
					rem_q   <= '0;
					cnt_q   <= 6'd0;
					state_q <= (state_q == S_RSET) ? S_RDIV : S_BDIV;
				end
				S_RDIV, S_DDIV, S_BDIV: begin
					// one quotient bit per cycle; the count wraps to zero at the end
					if (trial_rem_c >= 17'(den_q)) begin
						rem_q <= trial_rem_c - 17'(den_q);
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= trial_rem_c;
						quo_q <= {quo_q[62:0], 1'b0};
					end
					dn_q  <= {dn_q[62:0], 1'b0};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						unique case (state_q)
							S_RDIV: state_q <= S_MUL;
							S_DDIV: state_q <= S_GADD;
							default: state_q <= S_BUPD;
						endcase
						acc_q <= '0;
						ms_q  <= item_q.elapsed_ms;
					end
					if (state_q == S_RDIV && cnt_q == 6'd63)
						val_q <= (neg_q ? -$signed({quo_q[62:0], trial_rem_c >= 17'(den_q)})
							: $signed({quo_q[62:0], trial_rem_c >= 17'(den_q)})) + bias_c;
				end
				S_MUL: begin
					// shift and add, one bit of the elapsed time per cycle
					if (cnt_q == 6'd16) begin
						dn_q    <= (div_num_c[63] ? 64'(-div_num_c) : 64'(div_num_c))
							+ 64'(div_den_c >> 1);
						neg_q   <= div_num_c[63];
						den_q   <= div_den_c;
						rem_q   <= '0;
						cnt_q   <= 6'd0;
						state_q <= S_DDIV;
					end else begin
						if (ms_q[0])
							acc_q <= acc_q + val_q;
						val_q <= val_q <<< 1;
						ms_q  <= ms_q >> 1;
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_GADD: begin
					gyro_q[idx_q] <= sat32(64'(gyro_q[idx_q]) + div_res_c);
					if (idx_q == 2'd2) begin
						idx_q <= 2'd0;
						if (item_q.accel_ok) begin
							state_q <= S_SQB;
						end else begin
							status_q <= ictf_pkg::ST_ACC_FAIL;
							state_q  <= S_DONE;
						end
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= S_RSET;
					end
				end
				S_SQB: begin
					sq_q    <= 32'(b_c * b_c);
					state_q <= S_SQC;
				end
				S_SQC: begin
					m_q     <= 64'(sq_q + 32'(item_q.accel_z_raw * item_q.accel_z_raw)) << 28;
					srem_q  <= '0;
					root_q  <= '0;
					cnt_q   <= 6'd0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					// two radicand bits per cycle
					if (srem_sh_c >= strial_c) begin
						srem_q <= srem_sh_c - strial_c;
						root_q <= {root_q[30:0], 1'b1};
					end else begin
						srem_q <= srem_sh_c;
						root_q <= {root_q[30:0], 1'b0};
					end
					m_q <= {m_q[61:0], 2'b00};
					if (cnt_q == 6'd31) begin
						cx_q    <= 34'({root_q[30:0], srem_sh_c >= strial_c});
						cy_q    <= 34'(num_c) <<< 14;
						cz_q    <= '0;
						zero_q  <= ({root_q[30:0], srem_sh_c >= strial_c} == 32'd0)
							&& (num_c == 17'sd0);
						cnt_q   <= 6'd0;
						state_q <= S_CORD;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_CORD: begin
					// one vectoring step per cycle
					if (cy_q > 34'sd0) begin
						cx_q <= cx_q + ys_c;
						cy_q <= cy_q - xs_c;
						cz_q <= cz_q + $signed(33'(ictf_pkg::atan_deg(cnt_q[4:0])));
					end else begin
						cx_q <= cx_q - ys_c;
						cy_q <= cy_q + xs_c;
						cz_q <= cz_q - $signed(33'(ictf_pkg::atan_deg(cnt_q[4:0])));
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(NSTEP - 1))
						state_q <= S_TSET;
				end
				S_TSET: begin
					tilt_q[idx_q[0]] <= sat32(tilt_sum_c);
					if (idx_q[0]) begin
						idx_q   <= 2'd0;
						state_q <= S_BSET;
					end else begin
						idx_q   <= 2'd1;
						state_q <= S_SQB;
					end
				end
				S_BUPD: begin
					gyro_q[idx_q[0]] <= sat32(div_res_c);
					if (idx_q[0]) begin
						pub_q[0] <= gyro_q[0];
						pub_q[1] <= sat32(div_res_c);
						pub_q[2] <= gyro_q[2];
						state_q  <= S_DONE;
					end else begin
						idx_q   <= 2'd1;
						state_q <= S_BSET;
					end
				end
				S_DONE: begin
					if (!out_valid || out_ready) begin
						out_data.angle_x <= gyro_q[0];
						out_data.angle_y <= gyro_q[1];
						out_data.angle_z <= gyro_q[2];
						out_data.tilt_x  <= tilt_q[0];
						out_data.tilt_y  <= tilt_q[1];
						out_data.pos_x   <= pub_q[0];
						out_data.pos_y   <= pub_q[1];
						out_data.pos_z   <= pub_q[2];
						out_data.status  <= status_q;
						out_valid        <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
